// ===== rtl/mgps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgps_pkg
// Shared widths, beat types and controller/datapath command types for the
// masked gaussian path smoother.
// ----------------------------------------------------------------------------
package mgps_pkg;

  // fixed field widths
  localparam int COORD_WIDTH = 20;
  localparam int CFG_WIDTH   = 4;

  // parameter defaults
  localparam int MAX_SIGMA_DEF    = 15;
  localparam int WEIGHT_WIDTH_DEF = 16;

  // widths that cover the whole parameter range (max sigma up to 63)
  localparam int IDX_WIDTH  = 7;
  localparam int DIST_WIDTH = 6;

  // input beat
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic                          visible;
    logic                          path_end;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] smooth_x;
    logic signed [COORD_WIDTH-1:0] smooth_y;
    logic                          last_of_path;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic                  wr;
    logic                  rd_raw;
    logic                  clr;
    logic                  tap_vld;
    logic [IDX_WIDTH-1:0]  idx;
    logic [DIST_WIDTH-1:0] tap_dist;
    logic [DIST_WIDTH-1:0] sig;
    logic                  div_start;
    logic                  load_out;
    logic                  last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
  } status_t;

endpackage

// ===== rtl/mgps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgps_ram
// Simple dual port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mgps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mgps_weight_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgps_weight_rom
// Gaussian weight table exp(-d^2/(2 s^2)) in unsigned Q0.WEIGHT_WIDTH,
// built at elaboration from a 12th order Taylor series in Q0.32.
// ----------------------------------------------------------------------------
module mgps_weight_rom #(
  parameter int MAX_SIGMA    = 15,
  parameter int WEIGHT_WIDTH = 16
) (
  input  logic [$clog2(MAX_SIGMA+1)-1:0] sigma_i,
  input  logic [$clog2(MAX_SIGMA+1)-1:0] dist_i,
  output logic [WEIGHT_WIDTH-1:0]        weight_o
);

  localparam logic [63:0] ONE = 64'h1_0000_0000;
  localparam logic [63:0] CAP = (64'd1 << WEIGHT_WIDTH) - 64'd1;
  localparam logic [63:0] RND = 64'd1 << (31 - WEIGHT_WIDTH);

  logic [WEIGHT_WIDTH-1:0] rom [MAX_SIGMA+1][MAX_SIGMA+1];

  // table entries, one per sigma and distance
  for (genvar gs = 0; gs <= MAX_SIGMA; gs++) begin : g_sig
    for (genvar gd = 0; gd <= MAX_SIGMA; gd++) begin : g_dist
      if (gs == 0 || gd > gs) begin : g_unused
        assign rom[gs][gd] = '0;
      end else begin : g_entry
        localparam logic [63:0] X   = (64'(gd * gd) << 31) / 64'(gs * gs);
        localparam logic [63:0] T1  = ((ONE * X) >> 32) / 1;
        localparam logic [63:0] T2  = ((T1 * X) >> 32) / 2;
        localparam logic [63:0] T3  = ((T2 * X) >> 32) / 3;
        localparam logic [63:0] T4  = ((T3 * X) >> 32) / 4;
        localparam logic [63:0] T5  = ((T4 * X) >> 32) / 5;
        localparam logic [63:0] T6  = ((T5 * X) >> 32) / 6;
        localparam logic [63:0] T7  = ((T6 * X) >> 32) / 7;
        localparam logic [63:0] T8  = ((T7 * X) >> 32) / 8;
        localparam logic [63:0] T9  = ((T8 * X) >> 32) / 9;
        localparam logic [63:0] T10 = ((T9 * X) >> 32) / 10;
        localparam logic [63:0] T11 = ((T10 * X) >> 32) / 11;
        localparam logic [63:0] T12 = ((T11 * X) >> 32) / 12;
        localparam logic [63:0] SUM = ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8
                                      - T9 + T10 - T11 + T12;
        localparam logic [63:0] R   = (SUM + RND) >> (32 - WEIGHT_WIDTH);
        localparam logic [63:0] W   = (R > CAP) ? CAP : R;
        assign rom[gs][gd] = W[WEIGHT_WIDTH-1:0];
      end
    end
  end

  assign weight_o = rom[sigma_i][dist_i];

endmodule

// ===== rtl/mgps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgps_ctrl
// Controller: path bookkeeping, sigma register, emit sequencing over the
// window taps, output valid.
// ----------------------------------------------------------------------------
module mgps_ctrl #(
  parameter int MAX_SIGMA = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       path_end_i,
  input  logic                       cfg_we_i,
  input  logic [mgps_pkg::CFG_WIDTH-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  mgps_pkg::status_t          status_i,
  output mgps_pkg::cmd_t             cmd_o
);

  import mgps_pkg::*;

  localparam int DEPTH = 2 * MAX_SIGMA + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(MAX_SIGMA + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW,
    ST_TAPS,
    ST_DRAIN,
    ST_DIV
  } state_e;

  state_e             state_q;
  logic [CFG_WIDTH-1:0] sigma_q;
  logic [SW-1:0]      psig_q;
  logic [CNT_W-1:0]   seen_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SW-1:0]      age_q;
  logic [AW-1:0]      b_q;
  logic [AW-1:0]      hi_q;
  logic               flush_q;
  logic               out_valid_q;

  logic [6:0]       sig_ext;
  logic [6:0]       sig_clamp;
  logic [SW-1:0]    s_n;
  logic [CNT_W-1:0] cnt_n;
  logic [CNT_W-1:0] s_ext;
  logic [CNT_W-1:0] top_n;
  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] hi_n;
  logic [AW-1:0]    age_w;
  logic [AW-1:0]    dist_w;
  logic             out_free;
  logic             load;

  // sigma for a new path, clamped to MAX_SIGMA
  assign sig_ext   = 7'(sigma_q);
  assign sig_clamp = (sig_ext > 7'(MAX_SIGMA)) ? 7'(MAX_SIGMA) : sig_ext;
  assign s_n       = (seen_q == '0) ? sig_clamp[SW-1:0] : psig_q;
  assign s_ext     = CNT_W'(s_n);

  // points in window after this beat
  assign cnt_n = (seen_q == CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : seen_q + 1'b1;
  assign top_n = (s_ext < cnt_n - 1'b1) ? s_ext : cnt_n - 1'b1;

  // last tap of the window, cut at the oldest point of the path
  assign span = CNT_W'(age_q) + CNT_W'(psig_q);
  assign hi_n = (span < cnt_q - 1'b1) ? span : cnt_q - 1'b1;

  // distance of the current tap from the center
  assign age_w  = AW'(age_q);
  assign dist_w = (b_q > age_w) ? b_q - age_w : age_w - b_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign load     = (state_q == ST_DIV) && !status_i.div_busy && out_free;

  // state and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sigma_q     <= '0;
      psig_q      <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      age_q       <= '0;
      b_q         <= '0;
      hi_q        <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sigma_q <= cfg_data_i;
      end
      // output valid, a new load wins over the handshake
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            psig_q <= s_n;
            cnt_q  <= cnt_n;
            seen_q <= path_end_i ? '0 : cnt_n;
            if (path_end_i) begin
              age_q   <= top_n[SW-1:0];
              flush_q <= 1'b1;
              state_q <= ST_RAW;
            end else if (cnt_n > s_ext) begin
              age_q   <= s_n;
              flush_q <= 1'b0;
              state_q <= ST_RAW;
            end
          end
        end
        ST_RAW: begin
          b_q     <= '0;
          hi_q    <= hi_n[AW-1:0];
          state_q <= (psig_q == '0) ? ST_DRAIN : ST_TAPS;
        end
        ST_TAPS: begin
          if (b_q == hi_q) begin
            state_q <= ST_DRAIN;
          end else begin
            b_q <= b_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!status_i.pipe_busy) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (load) begin
            if (flush_q && age_q != '0) begin
              age_q   <= age_q - 1'b1;
              state_q <= ST_RAW;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.wr        = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.rd_raw    = (state_q == ST_RAW);
    cmd_o.clr       = (state_q == ST_RAW);
    cmd_o.tap_vld   = (state_q == ST_TAPS);
    cmd_o.idx       = (state_q == ST_RAW) ? IDX_WIDTH'(age_q) : IDX_WIDTH'(b_q);
    cmd_o.tap_dist  = DIST_WIDTH'(dist_w);
    cmd_o.sig       = DIST_WIDTH'(psig_q);
    cmd_o.div_start = (state_q == ST_DRAIN) && !status_i.pipe_busy;
    cmd_o.load_out  = load;
    cmd_o.last      = flush_q && (age_q == '0);
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/mgps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgps_datapath
// Window store, weight lookup, multiply-accumulate pipeline, two restoring
// dividers and the output register.
// ----------------------------------------------------------------------------
module mgps_datapath #(
  parameter int MAX_SIGMA    = 15,
  parameter int WEIGHT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mgps_pkg::in_beat_t  in_data_i,
  input  mgps_pkg::cmd_t      cmd_i,
  output mgps_pkg::status_t   status_o,
  output mgps_pkg::out_beat_t out_data_o
);

  import mgps_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int WW      = WEIGHT_WIDTH;
  localparam int DEPTH   = 2 * MAX_SIGMA + 2;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(MAX_SIGMA + 1);
  localparam int NORM_W  = WW + AW;
  localparam int PROD_W  = CW + WW + 1;
  localparam int ACC_W   = PROD_W + AW;
  localparam int ENTRY_W = 2 * CW + 1;
  localparam int DCNT_W  = $clog2(CW + 1);

  logic [AW-1:0]      wptr_q;
  logic [AW:0]        slot_sum;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [WW-1:0]      weight;

  logic                     raw_pend_q;
  logic signed [CW-1:0]     raw_x_q, raw_y_q;
  logic                     s1_vld_q;
  logic [SW-1:0]            s1_dist_q;
  logic                     s2_vld_q;
  logic [WW-1:0]            s2_w_q;
  logic signed [CW-1:0]     s2_x_q, s2_y_q;
  logic                     s3_vld_q;
  logic [WW-1:0]            s3_w_q;
  logic signed [PROD_W-1:0] px_q, py_q;
  logic signed [ACC_W-1:0]  acc_x_q, acc_y_q;
  logic [NORM_W-1:0]        norm_q;

  logic                 div_busy_q;
  logic [DCNT_W-1:0]    dcnt_q;
  logic [NORM_W-1:0]    rem_x_q, rem_y_q;
  logic [CW-1:0]        quo_x_q, quo_y_q;
  logic                 neg_x_q, neg_y_q;
  logic signed [CW-1:0] res_x_q, res_y_q;
  out_beat_t            out_q;

  logic [ACC_W-1:0]  mag_x, mag_y;
  logic [NORM_W:0]   trial_x, trial_y;
  logic              ge_x, ge_y;
  logic [NORM_W:0]   diff_x, diff_y;
  logic [CW-1:0]     qn_x, qn_y;

  // slot of a point by its age, newest is age zero
  assign slot_sum = (AW+1)'(wptr_q) + (AW+1)'(DEPTH - 1) - (AW+1)'(cmd_i.idx[AW-1:0]);
  assign raddr    = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                 : slot_sum[AW-1:0];

  mgps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .waddr_i(wptr_q),
    .wdata_i({in_data_i.visible, in_data_i.pos_y, in_data_i.pos_x}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  mgps_weight_rom #(
    .MAX_SIGMA   (MAX_SIGMA),
    .WEIGHT_WIDTH(WW)
  ) u_rom (
    .sigma_i (cmd_i.sig[SW-1:0]),
    .dist_i  (s1_dist_q),
    .weight_o(weight)
  );

  // write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
    end else if (cmd_i.wr) begin
      wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_pend_q <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
    end else begin
      raw_pend_q <= cmd_i.rd_raw;
      s1_vld_q   <= cmd_i.tap_vld;
      s2_vld_q   <= s1_vld_q && rdata[ENTRY_W-1];
      s3_vld_q   <= s2_vld_q;
    end
  end

  // raw point, tap data, weight and products
  always_ff @(posedge clk_i) begin
    if (raw_pend_q) begin
      raw_x_q <= rdata[CW-1:0];
      raw_y_q <= rdata[2*CW-1:CW];
    end
    s1_dist_q <= cmd_i.tap_dist[SW-1:0];
    s2_w_q    <= weight;
    s2_x_q    <= rdata[CW-1:0];
    s2_y_q    <= rdata[2*CW-1:CW];
    s3_w_q    <= s2_w_q;
    px_q      <= PROD_W'(s2_x_q) * $signed(PROD_W'({1'b0, s2_w_q}));
    py_q      <= PROD_W'(s2_y_q) * $signed(PROD_W'({1'b0, s2_w_q}));
  end

  // accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
      norm_q  <= '0;
    end else if (s3_vld_q) begin
      acc_x_q <= acc_x_q + ACC_W'(px_q);
      acc_y_q <= acc_y_q + ACC_W'(py_q);
      norm_q  <= norm_q + NORM_W'(s3_w_q);
    end
  end

  // divider step, one quotient bit per cycle for each axis
  assign mag_x   = acc_x_q[ACC_W-1] ? ACC_W'(-acc_x_q) : ACC_W'(acc_x_q);
  assign mag_y   = acc_y_q[ACC_W-1] ? ACC_W'(-acc_y_q) : ACC_W'(acc_y_q);
  assign trial_x = {rem_x_q, quo_x_q[CW-1]};
  assign trial_y = {rem_y_q, quo_y_q[CW-1]};
  assign ge_x    = trial_x >= {1'b0, norm_q};
  assign ge_y    = trial_y >= {1'b0, norm_q};
  assign diff_x  = ge_x ? trial_x - {1'b0, norm_q} : trial_x;
  assign diff_y  = ge_y ? trial_y - {1'b0, norm_q} : trial_y;
  assign qn_x    = {quo_x_q[CW-2:0], ge_x};
  assign qn_y    = {quo_y_q[CW-2:0], ge_y};

  // divider control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      dcnt_q     <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= (norm_q != '0);
      dcnt_q     <= DCNT_W'(CW);
    end else if (div_busy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (dcnt_q == DCNT_W'(1)) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  // divider data and quotients
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_x_q <= mag_x[CW+NORM_W-1:CW];
      rem_y_q <= mag_y[CW+NORM_W-1:CW];
      quo_x_q <= mag_x[CW-1:0];
      quo_y_q <= mag_y[CW-1:0];
      neg_x_q <= acc_x_q[ACC_W-1];
      neg_y_q <= acc_y_q[ACC_W-1];
      if (norm_q == '0) begin
        res_x_q <= raw_x_q;
        res_y_q <= raw_y_q;
      end
    end else if (div_busy_q) begin
      rem_x_q <= diff_x[NORM_W-1:0];
      rem_y_q <= diff_y[NORM_W-1:0];
      quo_x_q <= qn_x;
      quo_y_q <= qn_y;
      if (dcnt_q == DCNT_W'(1)) begin
        res_x_q <= neg_x_q ? CW'(-qn_x) : qn_x;
        res_y_q <= neg_y_q ? CW'(-qn_y) : qn_y;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.smooth_x     <= res_x_q;
      out_q.smooth_y     <= res_y_q;
      out_q.last_of_path <= cmd_i.last;
    end
  end

  assign status_o.pipe_busy = raw_pend_q || s1_vld_q || s2_vld_q || s3_vld_q;
  assign status_o.div_busy  = div_busy_q;
  assign out_data_o         = out_q;

endmodule

// ===== rtl/masked_gaussian_path_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_gaussian_path_smoother
// Gaussian weighted moving average over a stream of 2-D path points, using
// only visible points, window cut at the path ends.
// ----------------------------------------------------------------------------
// latency per result is spent on the raw read, the taps in the window (up to
//   2*sigma+1 of them), the accumulate pipeline drain, the divider steps (one
//   per quotient bit) and the output load; the block takes one beat at a time
//   and accepts the next only when idle; a path end flushes up to sigma+1 results
// the multiply-accumulate loop over the window and the bit-serial dividers set
//   the latency
// reset clears pointers, counters, sigma and valids; the window store is not
//   cleared, only entries written in the current path are read
module masked_gaussian_path_smoother #(
  parameter int MAX_SIGMA    = mgps_pkg::MAX_SIGMA_DEF,
  parameter int WEIGHT_WIDTH = mgps_pkg::WEIGHT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mgps_pkg::in_beat_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mgps_pkg::out_beat_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [mgps_pkg::CFG_WIDTH-1:0] cfg_data_i
);

  import mgps_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller
  mgps_ctrl #(
    .MAX_SIGMA(MAX_SIGMA)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .path_end_i (in_data_i.path_end),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  mgps_datapath #(
    .MAX_SIGMA   (MAX_SIGMA),
    .WEIGHT_WIDTH(WEIGHT_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_data_o(out_data_o)
  );

  // no result is loaded while a division is running
  a_load_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> !cmd.load_out)
    else $error("result loaded during division");

  // taps are only issued while no beat can be accepted
  a_tap_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tap_vld |-> !in_ready_o)
    else $error("tap issued while idle");

  // division starts only after the accumulate pipeline has drained
  a_div_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status.pipe_busy)
    else $error("division started with taps in flight");

  // a loaded result shows as valid in the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not valid");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the masked gaussian path smoother. A predictor
// keeps its own copy of the path window and sigma, computes every smoothed
// point as beats are accepted, and a checker compares each output beat
// against the oldest queued expectation. Directed paths come first, then
// random paths, first under random idling on both sides and then without.
// ----------------------------------------------------------------------------
module tb_top;
  import mgps_pkg::*;

  localparam int MAX_SIG     = 15;
  localparam int WGT_W       = 16;
  localparam int DEPTH       = 2 * MAX_SIG + 2;
  localparam int TAYLOR_N    = 12;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 200;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;
  logic      cfg_we_i;
  logic [CFG_WIDTH-1:0] cfg_data_i;

  masked_gaussian_path_smoother i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic signed [COORD_WIDTH-1:0] win_x   [DEPTH];
  logic signed [COORD_WIDTH-1:0] win_y   [DEPTH];
  logic                          win_vis [DEPTH];
  int unsigned wr_ptr;
  int unsigned path_len;
  int unsigned path_sig;
  int unsigned sigma_reg;

  out_beat_t smooth_q[$];
  int        err_cnt;
  longint    cyc_cnt;
  bit        idle_en;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cyc_cnt = 0;
    forever begin
      @(posedge clk_i);
      cyc_cnt++;
      if (cyc_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cyc_cnt);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // gaussian weight for distance d at spread s, unsigned Q0.WGT_W
  function automatic longint unsigned gauss_wgt(int unsigned d, int unsigned s);
    longint unsigned x, term, r, cap;
    longint          acc;
    x    = (longint'(d * d) << 31) / longint'(s * s);
    term = 64'd1 << 32;
    acc  = longint'(term);
    cap  = (64'd1 << WGT_W) - 1;
    for (int n = 1; n <= TAYLOR_N; n++) begin
      term = ((term * x) >> 32) / n;
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (longint'(acc) + (64'd1 << (31 - WGT_W))) >> (32 - WGT_W);
    return (r > cap) ? cap : r;
  endfunction

  function automatic int unsigned slot_at(int unsigned age);
    return (wr_ptr + DEPTH - 1 - age) % DEPTH;
  endfunction

  // smoothed point for the entry age back from the newest
  function automatic out_beat_t smooth_point(int unsigned age, int unsigned s,
                                             int unsigned cnt, bit last);
    out_beat_t   o;
    int unsigned c, e, d, lo;
    longint      ax, ay, norm, w, rx, ry;
    c  = slot_at(age);
    rx = win_x[c];
    ry = win_y[c];
    if (s > 0) begin
      lo   = (age > s) ? age - s : 0;
      ax   = 0;
      ay   = 0;
      norm = 0;
      for (int unsigned b = lo; b <= age + s && b < cnt; b++) begin
        e = slot_at(b);
        d = (b > age) ? b - age : age - b;
        if (win_vis[e]) begin
          w    = longint'(gauss_wgt(d, s));
          norm += w;
          ax   += longint'(win_x[e]) * w;
          ay   += longint'(win_y[e]) * w;
        end
      end
      if (norm > 0) begin
        rx = ax / norm;
        ry = ay / norm;
      end
    end
    o.smooth_x     = rx[COORD_WIDTH-1:0];
    o.smooth_y     = ry[COORD_WIDTH-1:0];
    o.last_of_path = last;
    return o;
  endfunction

  // advance the predictor by one accepted beat
  task automatic predict_beat(in_beat_t b);
    int unsigned cnt, top;
    if (path_len == 0) path_sig = (sigma_reg > MAX_SIG) ? MAX_SIG : sigma_reg;
    win_x[wr_ptr]   = b.pos_x;
    win_y[wr_ptr]   = b.pos_y;
    win_vis[wr_ptr] = b.visible;
    wr_ptr   = (wr_ptr + 1) % DEPTH;
    cnt      = (path_len < DEPTH) ? path_len + 1 : DEPTH;
    path_len = cnt;
    if (b.path_end) begin
      top = (path_sig < cnt - 1) ? path_sig : cnt - 1;
      for (int a = top; a >= 0; a--)
        smooth_q.push_back(smooth_point(a, path_sig, cnt, a == 0));
      path_len = 0;
    end else if (cnt > path_sig) begin
      smooth_q.push_back(smooth_point(path_sig, path_sig, cnt, 1'b0));
    end
  endtask

  task automatic report_err(string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // output side: random stalls, compare each beat
  initial begin
    out_beat_t exp_b;
    int        gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o) begin
        if (smooth_q.size() == 0) begin
          report_err("output beat with nothing expected");
        end else begin
          exp_b = smooth_q.pop_front();
          if (out_data_o.smooth_x !== exp_b.smooth_x)
            report_err($sformatf("smooth_x got %0d exp %0d",
                                 out_data_o.smooth_x, exp_b.smooth_x));
          if (out_data_o.smooth_y !== exp_b.smooth_y)
            report_err($sformatf("smooth_y got %0d exp %0d",
                                 out_data_o.smooth_y, exp_b.smooth_y));
          if (out_data_o.last_of_path !== exp_b.last_of_path)
            report_err($sformatf("last_of_path got %0b exp %0b",
                                 out_data_o.last_of_path, exp_b.last_of_path));
        end
      end
    end
  end

  // send one point, optional idle burst before it; valid stays up after the
  // accept until the next point or a drain takes it down
  task automatic send_point(logic signed [COORD_WIDTH-1:0] px,
                            logic signed [COORD_WIDTH-1:0] py, bit vis, bit last);
    in_beat_t b;
    b.pos_x    = px;
    b.pos_y    = py;
    b.visible  = vis;
    b.path_end = last;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(b);
    @(negedge clk_i);
  endtask

  // wait until all results have arrived, then a quiet spell
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (smooth_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_sigma(int unsigned s);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= s[CFG_WIDTH-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sigma_reg = s;
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      default: return COORD_WIDTH'($urandom());
    endcase
  endfunction

  task automatic send_path(int unsigned len, int unsigned vis_pct);
    for (int unsigned i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), $urandom_range(0, 99) < vis_pct,
                 i == len - 1);
  endtask

  // sigma zero passes points through, extremes of the coordinates
  task automatic test_passthrough();
    write_sigma(0);
    send_point({1'b1, {(COORD_WIDTH-1){1'b0}}}, {1'b0, {(COORD_WIDTH-1){1'b1}}},
               1'b1, 1'b0);
    send_point({1'b0, {(COORD_WIDTH-1){1'b1}}}, {1'b1, {(COORD_WIDTH-1){1'b0}}},
               1'b0, 1'b0);
    send_point('0, '1, 1'b1, 1'b1);
    wait_drained();
  endtask

  // extreme values, invisible window, short path, single point path
  task automatic test_directed();
    write_sigma(15);
    send_point({1'b0, {(COORD_WIDTH-1){1'b1}}}, {1'b1, {(COORD_WIDTH-1){1'b0}}},
               1'b1, 1'b0);
    send_point({1'b1, {(COORD_WIDTH-1){1'b0}}}, {1'b0, {(COORD_WIDTH-1){1'b1}}},
               1'b1, 1'b0);
    send_point(20'sd100, -20'sd100, 1'b1, 1'b1);
    wait_drained();
    write_sigma(3);
    send_point(20'sd5, 20'sd6, 1'b0, 1'b0);
    send_point(20'sd7, 20'sd8, 1'b0, 1'b0);
    send_point(20'sd9, 20'sd1, 1'b0, 1'b1);
    send_point(-20'sd9, 20'sd33, 1'b1, 1'b1);
    wait_drained();
  endtask

  // sigma written mid-path applies to the next path only
  task automatic test_sigma_midpath();
    write_sigma(2);
    send_point(20'sd10, 20'sd20, 1'b1, 1'b0);
    send_point(20'sd30, 20'sd40, 1'b1, 1'b0);
    wait_drained();
    write_sigma(9);
    send_point(20'sd50, 20'sd60, 1'b1, 1'b0);
    send_point(20'sd70, -20'sd80, 1'b1, 1'b0);
    send_point(-20'sd90, 20'sd99, 1'b1, 1'b1);
    wait_drained();
  endtask

  // random paths, mostly small sigma, with and without idling
  task automatic test_random(int unsigned n_items);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_items) begin
      write_sigma(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                               : $urandom_range(1, 5));
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 45)
                                        : $urandom_range(1, 12);
      if (len > n_items - sent) len = n_items - sent;
      send_path(len, $urandom_range(0, 3) == 0 ? 20 : 85);
      sent += len;
      wait_drained();
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    idle_en    = 1'b1;
    err_cnt    = 0;
    wr_ptr     = 0;
    path_len   = 0;
    path_sig   = 0;
    sigma_reg  = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_passthrough();
    test_directed();
    test_sigma_midpath();
    test_random(110);
    idle_en = 1'b0;
    test_random(35);
    wait_drained();

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
